// ===== rtl/tbpm_pkg.sv =====
`timescale 1ns / 1ps

package tbpm_pkg;

    localparam int SENSOR_WIDTH  = 384;
    localparam int SENSOR_HEIGHT = 384;
    localparam int MAX_SEGMENTS  = 256;
    localparam int SHADOW_ROWS   = 15;

    localparam int COORD_W = 9;
    localparam int TIME_W  = 64;
    localparam int VALUE_W = 16;
    localparam int SEG_AW  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
    // Signed width that holds sums and differences of two coordinates.
    localparam int CALC_W  = COORD_W + 3;

    localparam logic signed [TIME_W-1:0] TIME_INF = {1'b0, {(TIME_W-1){1'b1}}};

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [0:0]                opcode;
        logic [COORD_W-1:0]        entry_col;
        logic [COORD_W-1:0]        entry_row;
        logic [COORD_W-1:0]        entry_extent;
        logic signed [TIME_W-1:0]  time_start;
        logic signed [TIME_W-1:0]  time_end;
        logic [COORD_W-1:0]        pixel_col;
        logic [COORD_W-1:0]        pixel_row;
        logic signed [TIME_W-1:0]  query_time;
        logic [VALUE_W-1:0]        base_value;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] pixel_value;
        logic               masked;
        logic               table_full;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0]        col;
        logic [COORD_W-1:0]        row;
        logic [COORD_W-1:0]        extent;
        logic signed [TIME_W-1:0]  t_start;
        logic signed [TIME_W-1:0]  t_end;
    } t_segment;

    localparam int SEG_W = $bits(t_segment);

endpackage

// ===== rtl/tbpm_ram.sv =====
`timescale 1ns / 1ps

module tbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tbpm_seg_match.sv =====
`timescale 1ns / 1ps

module tbpm_seg_match
    import tbpm_pkg::*;
(
    input  t_segment                 i_seg,
    input  logic [COORD_W-1:0]       i_px,
    input  logic [COORD_W-1:0]       i_py,
    input  logic signed [TIME_W-1:0] i_tq,
    output logic                     o_hit
);

    logic signed [CALC_W-1:0] col_s;
    logic signed [CALC_W-1:0] row_s;
    logic signed [CALC_W-1:0] ext_s;
    logic signed [CALC_W-1:0] px_s;
    logic signed [CALC_W-1:0] py_s;
    logic signed [CALC_W-1:0] dx;
    logic signed [CALC_W-1:0] y_lo;
    logic signed [CALC_W-1:0] y_hi;
    logic                     active;
    logic                     in_col;
    logic                     in_side;

    always_comb begin
        col_s = $signed({3'b000, i_seg.col});
        row_s = $signed({3'b000, i_seg.row});
        ext_s = $signed({3'b000, i_seg.extent});
        px_s  = $signed({3'b000, i_px});
        py_s  = $signed({3'b000, i_py});

        // The stored column is 1-based, so the pixel offset is px - (col - 1).
        dx   = px_s - col_s + CALC_W'(1);
        // Rows covered by the segment, 0-based: row - 1 .. row + extent - 2.
        y_lo = row_s - CALC_W'(1);
        y_hi = row_s + ext_s - CALC_W'(2);

        active = (i_tq >= i_seg.t_start)
              && ((i_seg.t_end == TIME_INF) || (i_tq < i_seg.t_end));

        // The segment column also masks one row above and below.
        in_col  = (dx == '0) && (py_s >= y_lo - CALC_W'(1)) && (py_s <= y_hi + CALC_W'(1));
        in_side = ((dx == CALC_W'(1)) || (dx == -CALC_W'(1)))
               && (py_s >= y_lo) && (py_s <= y_hi);

        o_hit = active && (i_seg.extent != '0) && (in_col || in_side);
    end

endmodule

// ===== rtl/timed_bad_pixel_mask.sv =====
`timescale 1ns / 1ps
// For loads, and for queries on border or shadow pixels or an empty table, the result
// strobes in the cycle after acceptance. Other queries scan the segment memory one entry
// per cycle through its single read port, and the scan stops at the first hit.
// busy is high during a scan.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset clears the segment count, the shadow enable and control.

module timed_bad_pixel_mask
    import tbpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    output logic      o_valid,
    output t_out_item o_result
);

    t_state r_state, n_state;

    logic               r_shadow_en;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_valid, n_valid;
    t_out_item          r_out, n_out;

    logic [COORD_W-1:0]       r_px, r_py;
    logic signed [TIME_W-1:0] r_tq;
    logic [VALUE_W-1:0]       r_value;

    logic        accept;
    logic        is_query;
    logic        pre_masked;
    logic        ram_we;
    logic        ram_re;
    logic [SEG_AW-1:0] ram_raddr;
    t_segment    wr_seg;
    t_segment    rd_seg;
    logic [SEG_W-1:0] rd_bits;
    logic        hit;
    logic        scan_end;

    assign accept   = start && !busy;
    assign is_query = (i_item.opcode == OP_QUERY);

    always_comb begin
        pre_masked = (i_item.pixel_col == '0) || (i_item.pixel_row == '0)
                  || ({1'b0, i_item.pixel_col} >= (COORD_W+1)'(SENSOR_WIDTH - 1))
                  || ({1'b0, i_item.pixel_row} >= (COORD_W+1)'(SENSOR_HEIGHT - 1))
                  || (r_shadow_en
                      && ({1'b0, i_item.pixel_row} < (COORD_W+1)'(SHADOW_ROWS)));
    end

    always_comb begin
        wr_seg.col     = i_item.entry_col;
        wr_seg.row     = i_item.entry_row;
        wr_seg.extent  = i_item.entry_extent;
        wr_seg.t_start = i_item.time_start;
        wr_seg.t_end   = i_item.time_end;
    end

    assign rd_seg = t_segment'(rd_bits);

    tbpm_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[SEG_AW-1:0]),
        .i_wdata(wr_seg),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_bits)
    );

    tbpm_seg_match u_match (
        .i_seg(rd_seg),
        .i_px (r_px),
        .i_py (r_py),
        .i_tq (r_tq),
        .o_hit(hit)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_query && !pre_masked && (r_count != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        busy      = (r_state == S_SCAN);
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_idx[SEG_AW-1:0];
        scan_end  = 1'b0;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pend    = 1'b0;
        n_valid   = 1'b0;
        n_out     = '0;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    n_valid = 1'b1;
                    if (!is_query) begin
                        if (r_count < CNT_W'(MAX_SEGMENTS)) begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_out.table_full = 1'b1;
                        end
                    end else if (pre_masked) begin
                        n_out.masked = 1'b1;
                    end else if (r_count == '0) begin
                        n_out.pixel_value = i_item.base_value;
                    end else begin
                        // The scan reports later.
                        n_valid = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                // A pending read holds the entry addressed in the previous cycle.
                if (r_pend && hit) begin
                    scan_end     = 1'b1;
                    n_valid      = 1'b1;
                    n_out.masked = 1'b1;
                end else if ((r_idx == r_count) && !r_pend) begin
                    scan_end          = 1'b1;
                    n_valid           = 1'b1;
                    n_out.pixel_value = r_value;
                end else if (r_idx != r_count) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                    n_pend = 1'b1;
                end
            end
            default: begin
                scan_end = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_shadow_en <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_shadow_en <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (accept) begin
            r_px    <= i_item.pixel_col;
            r_py    <= i_item.pixel_row;
            r_tq    <= i_item.query_time;
            r_value <= i_item.base_value;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tbpm_pkg::*;

    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     REPORT_LIMIT = 10;
    localparam longint TIME_NEG_INF = 64'sh8000_0000_0000_0000;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      cfg_we;
    logic      cfg_data;
    logic      o_valid;
    t_out_item o_result;

    // Shadow copy of the segment table, the count and the shadow register.
    t_segment  seg_store [MAX_SEGMENTS];
    int        seg_count   = 0;
    bit        shadow_on   = 1'b0;

    t_out_item expected_results [$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;

    timed_bad_pixel_mask uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Applies one transaction to the shadow table and returns the result it should yield.
    function automatic t_out_item predict_mask_result(input t_in_item it);
        t_out_item res;
        t_segment  seg;
        int        px;
        int        py;
        int        x;
        int        ylo;
        int        yhi;
        int        dx;
        longint    tq;
        longint    ts;
        longint    te;
        bit        hit;
        res = '0;
        if (it.opcode == OP_LOAD) begin
            if (seg_count < MAX_SEGMENTS) begin
                seg.col     = it.entry_col;
                seg.row     = it.entry_row;
                seg.extent  = it.entry_extent;
                seg.t_start = it.time_start;
                seg.t_end   = it.time_end;
                seg_store[seg_count] = seg;
                seg_count++;
            end else begin
                res.table_full = 1'b1;
            end
            return res;
        end
        px  = int'(it.pixel_col);
        py  = int'(it.pixel_row);
        tq  = it.query_time;
        hit = (px <= 0 || py <= 0 || px >= SENSOR_WIDTH - 1 || py >= SENSOR_HEIGHT - 1);
        if (shadow_on && py < SHADOW_ROWS)
            hit = 1'b1;
        for (int i = 0; i < seg_count && !hit; i++) begin
            seg = seg_store[i];
            ts  = seg.t_start;
            te  = seg.t_end;
            if (tq >= ts && (te == TIME_INF || tq < te) && seg.extent != 0) begin
                x   = int'(seg.col) - 1;
                ylo = int'(seg.row) - 1;
                yhi = ylo + int'(seg.extent) - 1;
                dx  = px - x;
                // The segment column gets one extra row at each end, its neighbors do not.
                if (dx == 0)
                    hit = (py >= ylo - 1 && py <= yhi + 1);
                else if (dx == 1 || dx == -1)
                    hit = (py >= ylo && py <= yhi);
            end
        end
        res.masked      = hit;
        res.pixel_value = hit ? '0 : it.base_value;
        return res;
    endfunction

    function automatic longint random_tick();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.opcode       = 1'($urandom_range(0, 1));
        it.entry_col    = 9'($urandom);
        it.entry_row    = 9'($urandom);
        it.entry_extent = 9'($urandom);
        it.time_start   = random_tick();
        it.time_end     = random_tick();
        it.pixel_col    = 9'($urandom);
        it.pixel_row    = 9'($urandom);
        it.query_time   = random_tick();
        it.base_value   = 16'($urandom);
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            if ($urandom_range(0, 9) == 0)
                burst_left = $urandom_range(5, 30);
            gap = $urandom_range(0, 12);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        expected_results.insert(expected_results.size(), predict_mask_result(it));
    endtask

    task automatic send_load(input int col, input int row, input int ext,
                             input longint ts, input longint te);
        t_in_item it;
        it              = random_item();
        it.opcode       = OP_LOAD;
        it.entry_col    = 9'(col);
        it.entry_row    = 9'(row);
        it.entry_extent = 9'(ext);
        it.time_start   = ts;
        it.time_end     = te;
        send_item(it);
    endtask

    task automatic send_query(input int col, input int row, input longint tq, input int val);
        t_in_item it;
        it            = random_item();
        it.opcode     = OP_QUERY;
        it.pixel_col  = 9'(col);
        it.pixel_row  = 9'(row);
        it.query_time = tq;
        it.base_value = 16'(val);
        send_item(it);
    endtask

    // The register may only change while no transaction is in flight.
    task automatic write_shadow(input bit on);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= on;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        shadow_on = on;
    endtask

    task automatic random_load();
        t_in_item it;
        longint   ts;
        longint   te;
        it        = random_item();
        it.opcode = OP_LOAD;
        it.entry_col = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                   : 9'($urandom_range(1, 384));
        it.entry_row = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                   : 9'($urandom_range(1, 384));
        it.entry_extent = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                                      : 9'($urandom_range(0, 8));
        ts = longint'($urandom_range(0, 2000)) - 1000;
        te = ts + longint'($urandom_range(0, 2000));
        case ($urandom_range(0, 7))
            0: ts = TIME_NEG_INF;
            1: te = TIME_INF;
            2: begin
                ts = TIME_NEG_INF;
                te = TIME_INF;
            end
            3: begin
                ts = random_tick();
                te = random_tick();
            end
            4: te = ts;
            5: te = ts - longint'($urandom_range(1, 50));
            default: ;
        endcase
        it.time_start = ts;
        it.time_end   = te;
        send_item(it);
    endtask

    // Most queries aim at the neighborhood and time window of a stored segment.
    task automatic random_query();
        t_in_item it;
        t_segment seg;
        int       px;
        int       py;
        int       sel;
        longint   tq;
        it        = random_item();
        it.opcode = OP_QUERY;
        sel       = $urandom_range(0, 9);
        if (sel <= 5 && seg_count > 0) begin
            seg = seg_store[$urandom_range(0, seg_count - 1)];
            px  = int'(seg.col) - 3 + int'($urandom_range(0, 4));
            py  = int'(seg.row) - 3 + int'($urandom_range(0, int'(seg.extent) + 3));
            case ($urandom_range(0, 5))
                0: tq = seg.t_start;
                1: tq = seg.t_end;
                2: tq = seg.t_end - 1;
                3: tq = seg.t_start - 1;
                4: tq = seg.t_start + longint'($urandom_range(0, 1000));
                default: tq = random_tick();
            endcase
            it.pixel_col  = px[8:0];
            it.pixel_row  = py[8:0];
            it.query_time = tq;
        end else if (sel <= 8) begin
            it.pixel_col = 9'($urandom_range(0, 383));
            it.pixel_row = (sel == 6) ? 9'($urandom_range(0, 20)) : 9'($urandom_range(0, 383));
            if ($urandom_range(0, 3) != 0)
                it.query_time = longint'($urandom_range(0, 2000)) - 1000;
        end
        send_item(it);
    endtask

    task automatic test_border_pixels();
        send_query(0, 0, 0, 16'h1234);
        send_query(383, 383, 0, 16'h4321);
        send_query(1, 1, TIME_NEG_INF, 16'hFFFF);
        send_query(382, 382, TIME_INF, 16'h0000);
        send_query(511, 511, 5, 16'h8000);
    endtask

    task automatic test_shadow_rows();
        write_shadow(1'b1);
        send_query(200, 14, 0, 16'h7FFF);
        send_query(200, 15, 0, 16'h7FFF);
        send_query(5, 1, 0, 16'h0001);
        write_shadow(1'b0);
    endtask

    task automatic test_segment_shapes();
        send_load(0, 10, 5, TIME_NEG_INF, TIME_INF);
        send_load(1, 20, 3, TIME_NEG_INF, TIME_INF);
        send_load(100, 100, 3, -10, 10);
        send_load(200, 50, 0, TIME_NEG_INF, TIME_INF);
        send_load(300, 200, 4, 20, 20);
        send_load(250, 250, 1, TIME_INF, TIME_INF);
        send_load(511, 511, 511, random_tick(), random_tick());
        // A segment at column zero sits off the sensor; only column 0 neighbors it.
        send_query(1, 20, 0, 16'h0101);
        send_query(1, 12, 0, 16'h0202);
        send_query(99, 98, 0, 16'h0303);
        send_query(100, 98, 0, 16'h0404);
        send_query(98, 100, -10, 16'h0505);
        send_query(99, 102, 9, 16'h0606);
        send_query(99, 100, 10, 16'h0707);
        send_query(200, 50, 0, 16'h0808);
        send_query(299, 201, 20, 16'h0909);
        send_query(249, 249, TIME_INF, 16'h0A0A);
        send_query(249, 249, TIME_INF - 1, 16'h0B0B);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_shadow(phase[0]);
            repeat (160) begin
                if ($urandom_range(0, 9) < 3)
                    random_load();
                else
                    random_query();
            end
        end
    endtask

    task automatic test_full_table();
        while (seg_count < MAX_SEGMENTS)
            random_load();
        repeat (6) random_load();
        write_shadow(1'b0);
        repeat (8) random_query();
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("%0t: unexpected transaction: value %h masked %b full %b",
                             $time, o_result.pixel_value, o_result.masked,
                             o_result.table_full);
            end else begin
                want = expected_results.pop_front();
                if (o_result.pixel_value !== want.pixel_value ||
                    o_result.masked !== want.masked ||
                    o_result.table_full !== want.table_full) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: mismatch: expected value %h masked %b full %b,",
                                 $time, want.pixel_value, want.masked, want.table_full);
                        $display("    got value %h masked %b full %b",
                                 o_result.pixel_value, o_result.masked,
                                 o_result.table_full);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_item   <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_border_pixels();
        test_shadow_rows();
        test_segment_shapes();
        test_random_traffic();
        test_full_table();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // A full scan is the longest the block can take, so watch that long for strays.
        repeat (MAX_SEGMENTS + 4) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
